/* hw/rtl/lpbe_pkg.sv */
// ---------------------------------------------------------------------------
// lpbe_pkg
// Shared types and constants of the LED pixel bit encoder.
// ---------------------------------------------------------------------------
package lpbe_pkg;

  localparam int unsigned ByteW       = 8;
  localparam int unsigned PixelBits   = 3 * ByteW;
  localparam int unsigned SegsPerPixel = 2 * PixelBits;
  localparam int unsigned SegCntW     = $clog2(SegsPerPixel + 1);
  localparam int unsigned TickW       = 8;
  localparam int unsigned DurW        = 16;
  localparam int unsigned CfgAddrW    = 3;
  localparam int unsigned CfgDataW    = 16;
  localparam int unsigned OrderW      = 3;
  localparam int unsigned QueueDepth  = 2;
  localparam int unsigned QueuePtrW   = $clog2(QueueDepth);
  localparam int unsigned QueueCntW   = $clog2(QueueDepth + 1);

  // Configuration register indexes
  localparam logic [CfgAddrW-1:0] CfgColorOrder   = 3'd0;
  localparam logic [CfgAddrW-1:0] CfgOneHighTicks = 3'd1;
  localparam logic [CfgAddrW-1:0] CfgOneLowTicks  = 3'd2;
  localparam logic [CfgAddrW-1:0] CfgZeroHighTicks = 3'd3;
  localparam logic [CfgAddrW-1:0] CfgZeroLowTicks = 3'd4;
  localparam logic [CfgAddrW-1:0] CfgResetTicks   = 3'd5;

  // Color order codes
  localparam logic [OrderW-1:0] OrderRgb = 3'd0;
  localparam logic [OrderW-1:0] OrderRbg = 3'd1;
  localparam logic [OrderW-1:0] OrderGrb = 3'd2;
  localparam logic [OrderW-1:0] OrderGbr = 3'd3;
  localparam logic [OrderW-1:0] OrderBrg = 3'd4;
  localparam logic [OrderW-1:0] OrderBgr = 3'd5;

  // Reset values
  localparam logic [OrderW-1:0] RstColorOrder   = OrderGrb;
  localparam logic [TickW-1:0]  RstOneHighTicks = 8'd11;
  localparam logic [TickW-1:0]  RstOneLowTicks  = 8'd10;
  localparam logic [TickW-1:0]  RstZeroHighTicks = 8'd6;
  localparam logic [TickW-1:0]  RstZeroLowTicks = 8'd13;
  localparam logic [DurW-1:0]   RstResetTicks   = 16'd800;

  // Pixel as queued: bits[PixelBits-1] goes out first
  typedef struct packed {
    logic [PixelBits-1:0] bits;
    logic                 last;
  } pixel_t;

  typedef struct packed {
    logic [TickW-1:0] one_high;
    logic [TickW-1:0] one_low;
    logic [TickW-1:0] zero_high;
    logic [TickW-1:0] zero_low;
    logic [DurW-1:0]  reset_len;
  } tick_cfg_t;

  function automatic logic [PixelBits-1:0] reorder(input logic [OrderW-1:0] order,
                                                   input logic [ByteW-1:0]  r,
                                                   input logic [ByteW-1:0]  g,
                                                   input logic [ByteW-1:0]  b);
    logic [PixelBits-1:0] res;
    unique case (order)
      OrderRgb: res = {r, g, b};
      OrderRbg: res = {r, b, g};
      OrderGrb: res = {g, r, b};
      OrderGbr: res = {g, b, r};
      OrderBrg: res = {b, r, g};
      OrderBgr: res = {b, g, r};
      default:  res = {r, g, b};
    endcase
    return res;
  endfunction

endpackage

/* hw/rtl/led_pixel_bit_encoder.sv */
// ---------------------------------------------------------------------------
// led_pixel_bit_encoder
// Encodes pixels into high/low line segments for a one-wire LED chain.
// ---------------------------------------------------------------------------
// Path: with the sequencer idle, an accepted pixel is written to the queue,
//   loaded into the sequencer's shift register, then its first segment is
//   registered. Segments: 48 per pixel, 49 for a pixel marked last; the
//   sequencer emits one segment per cycle unless the output stalls.
// Reset: configuration returns to GRB order, ticks 11/10/6/13, latch 800;
//   the queue empties and no segment is offered.
module led_pixel_bit_encoder import lpbe_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgAddrW-1:0] cfg_addr_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [23:0]         s_axis_tdata,  // red[7:0], green[15:8], blue[23:16]
  input  logic                s_axis_tlast,  // last pixel of frame
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [23:0]         m_axis_tdata,  // line_level[0], duration[16:1], zero[23:17]
  output logic                m_axis_tlast   // end of run
);

  logic [OrderW-1:0] color_order_q;
  tick_cfg_t         ticks_q;

  logic   q_full;
  logic   q_push;
  pixel_t q_push_data;
  logic   q_pop;
  logic   q_valid;
  pixel_t q_head;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      color_order_q     <= RstColorOrder;
      ticks_q.one_high  <= RstOneHighTicks;
      ticks_q.one_low   <= RstOneLowTicks;
      ticks_q.zero_high <= RstZeroHighTicks;
      ticks_q.zero_low  <= RstZeroLowTicks;
      ticks_q.reset_len <= RstResetTicks;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        CfgColorOrder:    color_order_q     <= cfg_wdata_i[OrderW-1:0];
        CfgOneHighTicks:  ticks_q.one_high  <= cfg_wdata_i[TickW-1:0];
        CfgOneLowTicks:   ticks_q.one_low   <= cfg_wdata_i[TickW-1:0];
        CfgZeroHighTicks: ticks_q.zero_high <= cfg_wdata_i[TickW-1:0];
        CfgZeroLowTicks:  ticks_q.zero_low  <= cfg_wdata_i[TickW-1:0];
        CfgResetTicks:    ticks_q.reset_len <= cfg_wdata_i[DurW-1:0];
        default: ;  // drop writes to unknown indexes
      endcase
    end
  end

  lpbe_front u_front (
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .color_order_i (color_order_q),
    .q_full_i      (q_full),
    .q_push_o      (q_push),
    .q_pixel_o     (q_push_data)
  );

  lpbe_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (q_push_data),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .head_o      (q_head)
  );

  lpbe_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ticks_i       (ticks_q),
    .q_valid_i     (q_valid),
    .q_head_i      (q_head),
    .q_pop_o       (q_pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

/* hw/rtl/lpbe_front.sv */
// ---------------------------------------------------------------------------
// lpbe_front
// Input side: accepts a pixel, puts its bytes in send order, pushes it.
// ---------------------------------------------------------------------------
module lpbe_front import lpbe_pkg::*; (
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [23:0]       s_axis_tdata,  // red[7:0], green[15:8], blue[23:16]
  input  logic              s_axis_tlast,  // last pixel of frame
  input  logic [OrderW-1:0] color_order_i,
  input  logic              q_full_i,
  output logic              q_push_o,
  output pixel_t            q_pixel_o
);

  assign s_axis_tready = !q_full_i;
  assign q_push_o      = s_axis_tvalid && !q_full_i;

  always_comb begin
    q_pixel_o.bits = reorder(color_order_i,
                             s_axis_tdata[ByteW-1:0],
                             s_axis_tdata[2*ByteW-1:ByteW],
                             s_axis_tdata[3*ByteW-1:2*ByteW]);
    q_pixel_o.last = s_axis_tlast;
  end

endmodule

/* hw/rtl/lpbe_queue.sv */
// ---------------------------------------------------------------------------
// lpbe_queue
// Short pixel queue between the front and the segment sequencer.
// ---------------------------------------------------------------------------
module lpbe_queue import lpbe_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  pixel_t push_data_i,
  output logic   full_o,
  input  logic   pop_i,
  output logic   valid_o,
  output pixel_t head_o
);

  pixel_t                 mem_q [QueueDepth];
  logic [QueuePtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [QueuePtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [QueueCntW-1:0]   cnt_q, cnt_d;

  assign full_o  = (cnt_q == QueueCntW'(QueueDepth));
  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == QueuePtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == QueuePtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

/* hw/rtl/lpbe_back.sv */
// ---------------------------------------------------------------------------
// lpbe_back
// Segment sequencer: turns a queued pixel into high/low line segments,
// one per cycle unless the output stalls, into an output register.
// ---------------------------------------------------------------------------
module lpbe_back import lpbe_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  tick_cfg_t   ticks_i,
  input  logic        q_valid_i,
  input  pixel_t      q_head_i,
  output logic        q_pop_o,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,  // line_level[0], duration[16:1], zero[23:17]
  output logic        m_axis_tlast   // end of run
);

  logic                 busy_q;
  logic [PixelBits-1:0] shreg_q;
  logic                 last_q;
  logic [SegCntW-1:0]   cnt_q;

  logic                 out_valid_q;
  logic                 out_level_q;
  logic [DurW-1:0]      out_dur_q;
  logic                 out_end_q;

  logic                 advance;
  logic                 load;
  logic                 latch_seg;
  logic                 bit_one;
  logic                 seg_level;
  logic [DurW-1:0]      seg_dur;
  logic                 seg_end;
  logic                 seg_final;

  assign advance = !out_valid_q || m_axis_tready;
  assign load    = busy_q && advance;
  assign bit_one = shreg_q[PixelBits-1];
  assign latch_seg = (cnt_q == SegCntW'(SegsPerPixel));

  always_comb begin
    if (latch_seg) begin
      seg_level = 1'b0;
      seg_dur   = ticks_i.reset_len;
      seg_end   = 1'b1;
      seg_final = 1'b1;
    end else if (!cnt_q[0]) begin
      seg_level = 1'b1;
      seg_dur   = DurW'(bit_one ? ticks_i.one_high : ticks_i.zero_high);
      seg_end   = 1'b0;
      seg_final = 1'b0;
    end else begin
      seg_level = 1'b0;
      seg_dur   = DurW'(bit_one ? ticks_i.one_low : ticks_i.zero_low);
      seg_end   = !last_q && (cnt_q == SegCntW'(SegsPerPixel - 1));
      seg_final = seg_end;
    end
  end

  // Take the next pixel when idle or as the current one emits its final segment
  assign q_pop_o = q_valid_i && (!busy_q || (load && seg_final));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (q_pop_o) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (load && seg_final) begin
        busy_q <= 1'b0;
      end else if (load) begin
        cnt_q <= cnt_q + 1'b1;
      end
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      shreg_q <= q_head_i.bits;
      last_q  <= q_head_i.last;
    end else if (load && cnt_q[0]) begin
      // advance to the next bit after its low segment
      shreg_q <= {shreg_q[PixelBits-2:0], 1'b0};
    end
    if (load) begin
      out_level_q <= seg_level;
      out_dur_q   <= seg_dur;
      out_end_q   <= seg_end;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {(24 - DurW - 1)'(0), out_dur_q, out_level_q};
  assign m_axis_tlast  = out_end_q;

endmodule

/* hw/rtl/lpbe_checker.sv */
// ---------------------------------------------------------------------------
// lpbe_checker
// Port-level checks of the LED pixel bit encoder, bound to the top level.
// ---------------------------------------------------------------------------
module lpbe_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata,
  input logic        m_axis_tlast
);

  // A stalled segment holds its value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tlast))
    else $error("stalled output segment changed");

  // A high segment never ends a run
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[0] |-> !m_axis_tlast)
    else $error("high segment marked end of run");

  // A high segment is always followed by a low one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && m_axis_tdata[0]
      |=> !m_axis_tvalid || !m_axis_tdata[0])
    else $error("two high segments in a row");

  // Padding bits above the duration stay zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[23:17] == 7'd0)
    else $error("output padding not zero");

endmodule

bind led_pixel_bit_encoder lpbe_checker u_lpbe_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);
